FILE: rtl/npbm_pkg.sv
// Shared types and constants for the netpbm header parser.
package npbm_pkg;

  localparam int unsigned MaxTokenLength = 64;
  localparam int unsigned TokLenW = $clog2(MaxTokenLength + 1);
  localparam logic [19:0] MaxDimension = 20'd1000000;
  localparam logic [19:0] SatValue = 20'd1000001;
  localparam logic [19:0] MaxvalRequired = 20'd255;

  localparam logic [7:0] ChPlus = 8'h2B;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChP = 8'h50;
  localparam logic [7:0] Ch5 = 8'h35;
  localparam logic [7:0] Ch6 = 8'h36;
  localparam logic [7:0] Ch0 = 8'h30;
  localparam logic [7:0] Ch9 = 8'h39;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;

  localparam logic [1:0] RkHeader = 2'd0;
  localparam logic [1:0] RkSample = 2'd1;
  localparam logic [1:0] RkError = 2'd2;
  localparam logic ErrRead = 1'b0;
  localparam logic ErrFormat = 1'b1;

  localparam int unsigned QueueDepth = 2;

  // Result as it travels from the parser to the output stage.
  typedef struct packed {
    logic [1:0]  result_kind;
    logic        error_code;
    logic [19:0] image_width;
    logic [19:0] image_height;
    logic [1:0]  channel_count;
    logic [7:0]  sample_value;
    logic        sample_last;
  } result_t;

endpackage

FILE: rtl/npbm_front.sv
// Parser front: classifies each byte and updates header and sample state.
module npbm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                kind,
  input  logic [7:0]          data_byte,
  output logic                res_valid,
  output npbm_pkg::result_t   res
);

  typedef enum logic [2:0] {
    PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_SAMPLES, PH_DONE
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic in_comment_r, in_comment_nxt;
  logic in_token_r, in_token_nxt;
  logic [npbm_pkg::TokLenW-1:0] tok_len_r, tok_len_nxt;
  logic [15:0] magic_r, magic_nxt;
  logic [19:0] acc_r, acc_nxt;
  logic digit_r, digit_nxt, bad_r, bad_nxt;
  logic [19:0] width_r, width_nxt, height_r, height_nxt;
  logic [1:0] chans_r, chans_nxt, ch_idx_r, ch_idx_nxt;
  logic [19:0] col_r, col_nxt, row_r, row_nxt;

  logic blank, is_digit, num_ok, last;
  logic [1:0] magic_ch;
  logic [23:0] acc_mul;
  logic [23:0] acc_sum;

  assign blank = (data_byte == npbm_pkg::ChSpace) ||
                 (data_byte >= npbm_pkg::ChTab && data_byte <= npbm_pkg::ChCr);
  assign is_digit = (data_byte >= npbm_pkg::Ch0) && (data_byte <= npbm_pkg::Ch9);
  assign num_ok = !bad_r && digit_r && (acc_r != 20'd0) && (acc_r <= npbm_pkg::MaxDimension);
  // acc*10 = acc*8 + acc*2
  assign acc_mul = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0};
  assign acc_sum = acc_mul + {20'd0, data_byte[3:0]};
  assign last = ({1'b0, ch_idx_r} + 3'd1 >= {1'b0, chans_r}) &&
                ({1'b0, col_r} + 21'd1 >= {1'b0, width_r}) &&
                ({1'b0, row_r} + 21'd1 >= {1'b0, height_r});

  always_comb begin
    magic_ch = 2'd0;
    if (tok_len_r == npbm_pkg::TokLenW'(2) && magic_r[15:8] == npbm_pkg::ChP) begin
      if (magic_r[7:0] == npbm_pkg::Ch5) magic_ch = 2'd1;
      else if (magic_r[7:0] == npbm_pkg::Ch6) magic_ch = 2'd3;
    end
  end

  always_comb begin
    phase_nxt = phase_r; in_comment_nxt = in_comment_r; in_token_nxt = in_token_r;
    tok_len_nxt = tok_len_r; magic_nxt = magic_r; acc_nxt = acc_r;
    digit_nxt = digit_r; bad_nxt = bad_r;
    width_nxt = width_r; height_nxt = height_r; chans_nxt = chans_r;
    ch_idx_nxt = ch_idx_r; col_nxt = col_r; row_nxt = row_r;
    res_valid = 1'b0;
    res = '0;

    if (kind) begin
      res_valid = 1'b1;
      res.result_kind = npbm_pkg::RkError;
      case (phase_r)
        PH_MAGIC: res.error_code = in_token_r ? npbm_pkg::ErrFormat : npbm_pkg::ErrRead;
        PH_WIDTH, PH_HEIGHT: res.error_code = npbm_pkg::ErrFormat;
        PH_MAXVAL: res.error_code = (in_token_r && num_ok &&
                    acc_r == npbm_pkg::MaxvalRequired) ? npbm_pkg::ErrRead
                                                       : npbm_pkg::ErrFormat;
        PH_SAMPLES: res.error_code = npbm_pkg::ErrRead;
        default: res_valid = 1'b0;
      endcase
      phase_nxt = PH_MAGIC; in_comment_nxt = 1'b0; in_token_nxt = 1'b0;
      tok_len_nxt = '0; magic_nxt = '0; acc_nxt = '0;
      digit_nxt = 1'b0; bad_nxt = 1'b0;
      width_nxt = '0; height_nxt = '0; chans_nxt = '0;
      ch_idx_nxt = '0; col_nxt = '0; row_nxt = '0;
    end else if (phase_r == PH_DONE) begin
      res_valid = 1'b0;
    end else if (phase_r == PH_SAMPLES) begin
      res_valid = 1'b1;
      res.result_kind = npbm_pkg::RkSample;
      res.sample_value = data_byte;
      res.sample_last = last;
      if (last) begin
        phase_nxt = PH_DONE;
      end else if (ch_idx_r + 2'd1 >= chans_r) begin
        ch_idx_nxt = '0;
        if (col_r + 20'd1 >= width_r) begin
          col_nxt = '0;
          row_nxt = row_r + 20'd1;
        end else begin
          col_nxt = col_r + 20'd1;
        end
      end else begin
        ch_idx_nxt = ch_idx_r + 2'd1;
      end
    end else if (in_comment_r) begin
      if (data_byte == npbm_pkg::ChLf || data_byte == npbm_pkg::ChCr) in_comment_nxt = 1'b0;
    end else if (!in_token_r && blank) begin
      res_valid = 1'b0;
    end else if (!in_token_r && data_byte == npbm_pkg::ChHash) begin
      in_comment_nxt = 1'b1;
    end else if (in_token_r && blank) begin
      // token ends here
      tok_len_nxt = '0; magic_nxt = '0; acc_nxt = '0; in_token_nxt = 1'b0;
      digit_nxt = 1'b0; bad_nxt = 1'b0;
      res.result_kind = npbm_pkg::RkError;
      res.error_code = npbm_pkg::ErrFormat;
      if (phase_r == PH_MAGIC) begin
        if (magic_ch == 2'd0) begin
          res_valid = 1'b1; phase_nxt = PH_DONE;
        end else begin
          chans_nxt = magic_ch; phase_nxt = PH_WIDTH;
        end
      end else if (!num_ok) begin
        res_valid = 1'b1; phase_nxt = PH_DONE;
      end else if (phase_r == PH_WIDTH) begin
        width_nxt = acc_r; phase_nxt = PH_HEIGHT;
      end else if (phase_r == PH_HEIGHT) begin
        height_nxt = acc_r; phase_nxt = PH_MAXVAL;
      end else if (acc_r != npbm_pkg::MaxvalRequired) begin
        res_valid = 1'b1; phase_nxt = PH_DONE;
      end else begin
        res_valid = 1'b1;
        res.result_kind = npbm_pkg::RkHeader;
        res.error_code = 1'b0;
        res.image_width = width_r;
        res.image_height = height_r;
        res.channel_count = chans_r;
        phase_nxt = PH_SAMPLES;
        ch_idx_nxt = '0; col_nxt = '0; row_nxt = '0;
      end
    end else if (in_token_r && (tok_len_r + npbm_pkg::TokLenW'(1) >=
                                npbm_pkg::TokLenW'(npbm_pkg::MaxTokenLength))) begin
      res_valid = 1'b1;
      res.result_kind = npbm_pkg::RkError;
      res.error_code = (phase_r == PH_MAGIC) ? npbm_pkg::ErrRead : npbm_pkg::ErrFormat;
      phase_nxt = PH_DONE;
      tok_len_nxt = '0; magic_nxt = '0; acc_nxt = '0; in_token_nxt = 1'b0;
      digit_nxt = 1'b0; bad_nxt = 1'b0;
    end else begin
      in_token_nxt = 1'b1;
      tok_len_nxt = tok_len_r + 1'b1;
      if (phase_r == PH_MAGIC) begin
        if (tok_len_r < npbm_pkg::TokLenW'(2)) magic_nxt = {magic_r[7:0], data_byte};
      end else if (is_digit) begin
        digit_nxt = 1'b1;
        acc_nxt = (acc_sum > {4'd0, npbm_pkg::MaxDimension}) ? npbm_pkg::SatValue
                                                             : acc_sum[19:0];
      end else if (!(tok_len_r == '0 && data_byte == npbm_pkg::ChPlus)) begin
        // only a leading '+' is allowed besides digits
        bad_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC; in_comment_r <= 1'b0; in_token_r <= 1'b0;
      tok_len_r <= '0; magic_r <= '0; acc_r <= '0;
      digit_r <= 1'b0; bad_r <= 1'b0;
      width_r <= '0; height_r <= '0; chans_r <= '0;
      ch_idx_r <= '0; col_r <= '0; row_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt; in_comment_r <= in_comment_nxt; in_token_r <= in_token_nxt;
      tok_len_r <= tok_len_nxt; magic_r <= magic_nxt; acc_r <= acc_nxt;
      digit_r <= digit_nxt; bad_r <= bad_nxt;
      width_r <= width_nxt; height_r <= height_nxt; chans_r <= chans_nxt;
      ch_idx_r <= ch_idx_nxt; col_r <= col_nxt; row_r <= row_nxt;
    end
  end

endmodule

FILE: rtl/npbm_queue.sv
// Short result queue between parser and output port.
module npbm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  npbm_pkg::result_t wr_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output npbm_pkg::result_t out_data
);

  localparam int unsigned AW = $clog2(npbm_pkg::QueueDepth);

  npbm_pkg::result_t mem_r [npbm_pkg::QueueDepth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  logic rd_en;

  assign rd_en = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign full = (cnt_r == (AW+1)'(npbm_pkg::QueueDepth));
  assign out_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

endmodule

FILE: rtl/netpbm_binary_header_parser_top.sv
// Top level of the binary netpbm header parser.
// Takes one byte or end-of-stream marker per cycle, unless stalled, and gives at most
// one result per byte. The parser state is registered on each transfer, and the result
// of a byte is written into the result queue on that transfer and offered from there. A
// two-entry result queue decouples the parser from the output, and the input stalls
// whenever that queue is full, which happens only after the downstream side has held off.
module netpbm_binary_header_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [1:0] result_kind, [2] error_code, [22:3] image_width,
                                  // [42:23] image_height, [44:43] channel_count,
                                  // [52:45] sample_value, [55:53] zero
  output logic        out_tlast   // sample_last
);

  logic step, full, res_valid;
  npbm_pkg::result_t res, q_data;

  assign in_tready = !full;
  assign step = in_tvalid && in_tready;

  npbm_front u_front (
    .clk(clk), .rst_n(rst_n), .step(step), .kind(in_tuser),
    .data_byte(in_tdata), .res_valid(res_valid), .res(res)
  );

  npbm_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(step && res_valid), .wr_data(res), .full(full),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(q_data)
  );

  assign out_tdata = {3'b000, q_data.sample_value, q_data.channel_count,
                      q_data.image_height, q_data.image_width, q_data.error_code,
                      q_data.result_kind};
  assign out_tlast = q_data.sample_last;

`ifndef SYNTH
  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !in_tready) else $error("input taken while queue full");
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != 2'd3)) else $error("bad result kind");
  a_last_is_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[1:0] == npbm_pkg::RkSample))
    else $error("last on non-sample");
`endif

endmodule
